>>> rtl/lis_pkg.sv
// Shared constants, types and the probe word format for the LIS chain.
`timescale 1ns / 1ps
package lis_pkg;

  // Capacity of the store, one cell each.
  localparam int MAX_ITEMS = 256;
  localparam int VAL_W = 32;
  localparam int LEN_W = 9;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

  localparam int OUT_FIELDS_W = 2 * LEN_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // A probe carries one new element down the chain of cells.
  typedef struct packed {
    logic                    act;
    logic                    written;
    logic signed [VAL_W-1:0] key;
    logic [LEN_W-1:0]        len;
  } probe_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

>>> rtl/lis_cell.sv
// One cell of the chain: holds a stored element and updates a passing probe.
`timescale 1ns / 1ps
module lis_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            occupied,
  input  lis_pkg::probe_t probe_in,
  output lis_pkg::probe_t probe_out
);
  import lis_pkg::*;

  logic signed [VAL_W-1:0] stored_val_r;
  logic [LEN_W-1:0]        stored_len_r;
  probe_t                  probe_r;
  probe_t                  probe_nxt;
  logic                    wr_en;
  logic [LEN_W:0]          cand_wide;
  logic [LEN_W-1:0]        cand;

  always_comb begin
    probe_nxt = probe_in;
    wr_en     = 1'b0;
    cand_wide = {1'b0, stored_len_r} + {{LEN_W{1'b0}}, 1'b1};
    cand      = (cand_wide > {1'b0, LEN_SAT}) ? LEN_SAT : cand_wide[LEN_W-1:0];
    if (probe_in.act) begin
      if (occupied) begin
        // Only a strictly smaller earlier element may extend the subsequence.
        if ((stored_val_r < probe_in.key) && (cand > probe_in.len)) begin
          probe_nxt.len = cand;
        end
      end else if (!probe_in.written) begin
        // First free cell: the element settles here with its final length.
        wr_en             = 1'b1;
        probe_nxt.written = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.act <= 1'b0;
    end else begin
      probe_r.act <= probe_nxt.act;
    end
    probe_r.written <= probe_nxt.written;
    probe_r.key     <= probe_nxt.key;
    probe_r.len     <= probe_nxt.len;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stored_val_r <= probe_in.key;
      stored_len_r <= probe_in.len;
    end
  end

  assign probe_out = probe_r;

endmodule

>>> rtl/longest_increasing_subsequence_unit.sv
// Top level of the streaming longest-increasing-subsequence unit.
`timescale 1ns / 1ps
// Each input word carries one signed 32-bit element (in_tdata) and a start
// flag (in_tuser). A set flag empties the store and clears the running best
// before the element is taken as the first of a new sequence. For every
// input word exactly one output word follows. It gives the length of the
// longest strictly increasing subsequence ending at that element and the
// best length of the current sequence so far. The store is a row of
// MAX_ITEMS identical cells. An accepted element travels down the row as a
// probe, one cell per cycle, picking up the largest length of any stored
// smaller element, and settles in the first free cell. The probe always
// walks the whole row, so the length of the cell chain sets the timing.
// The result passes through the result register into the output register,
// and only one element is in flight at a time: the next word is taken
// only once the result has moved into the output register. When the
// store is full the element is dropped at once. The output word carries
// an ending length of zero, the unchanged best and the overflow flag,
// and it too passes through the result register into the output
// register. A finished result waits in the output register
// while the unit goes back to accepting the next word. If that register is
// still held by the sink when the next result is ready, the unit waits and
// holds in_tready low until the sink takes the older word.
module longest_increasing_subsequence_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lis_pkg::VAL_W-1:0]       in_tdata,   // [31:0] value
  input  logic                            in_tuser,   // [0] start_new
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [8:0] ending_length, [17:9] best_length, upper bits zero
  output logic [lis_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser   // [0] overflow
);
  import lis_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] best_r, best_nxt;
  logic [LEN_W-1:0] res_len_r, res_len_nxt;
  logic [LEN_W-1:0] res_best_r, res_best_nxt;
  logic             res_ovf_r, res_ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  logic [LEN_W-1:0] out_best_r, out_best_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  probe_t           head_r, head_nxt;
  probe_t           link [MAX_ITEMS+1];
  logic             in_fire;
  logic             full_drop;

  assign in_fire   = in_tvalid && in_tready;
  // The store is full only if this word does not open a new sequence.
  assign full_drop = !in_tuser && (count_r == CNT_W'(MAX_ITEMS));

  assign link[0] = head_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      logic occ;
      assign occ = (CNT_W'(gi) < count_r);
      lis_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .occupied  (occ),
        .probe_in  (link[gi]),
        .probe_out (link[gi+1])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    res_len_nxt   = res_len_r;
    res_best_nxt  = res_best_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r;
    out_len_nxt   = out_len_r;
    out_best_nxt  = out_best_r;
    out_ovf_nxt   = out_ovf_r;
    head_nxt      = head_r;
    head_nxt.act  = 1'b0;
    in_tready     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          if (in_tuser) begin
            count_nxt = '0;
            best_nxt  = '0;
          end
          if (full_drop) begin
            res_len_nxt  = '0;
            res_best_nxt = best_r;
            res_ovf_nxt  = 1'b1;
            state_nxt    = ST_DONE;
          end else begin
            head_nxt.act     = 1'b1;
            head_nxt.written = 1'b0;
            head_nxt.key     = $signed(in_tdata);
            head_nxt.len     = {{(LEN_W-1){1'b0}}, 1'b1};
            state_nxt        = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // The probe leaves the last cell with its final ending length.
        if (link[MAX_ITEMS].act) begin
          res_len_nxt  = link[MAX_ITEMS].len;
          res_best_nxt = (link[MAX_ITEMS].len > best_r) ? link[MAX_ITEMS].len : best_r;
          res_ovf_nxt  = 1'b0;
          best_nxt     = res_best_nxt;
          count_nxt    = count_r + {{(CNT_W-1){1'b0}}, 1'b1};
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = res_len_r;
          out_best_nxt  = res_best_r;
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
      head_r.act  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      head_r.act  <= head_nxt.act;
    end
    head_r.written <= head_nxt.written;
    head_r.key     <= head_nxt.key;
    head_r.len     <= head_nxt.len;
  end

  always_ff @(posedge clk) begin
    res_len_r      <= res_len_nxt;
    res_best_r     <= res_best_nxt;
    res_ovf_r      <= res_ovf_nxt;
    out_len_r      <= out_len_nxt;
    out_best_r     <= out_best_nxt;
    out_ovf_r      <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_best_r, out_len_r};
  assign out_tuser  = out_ovf_r;

  // A probe may only be leaving the chain while the unit waits for it.
  a_probe_in_run : assert property (@(posedge clk) disable iff (!rst_n)
    link[MAX_ITEMS].act |-> (state_r == ST_RUN))
    else $error("probe left the chain outside the run state");

  // The fill count never passes the capacity of the row.
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond capacity");

  // A dropped element goes straight to the result stage flagged as overflow.
  a_drop_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full_drop) |=> ((state_r == ST_DONE) && res_ovf_r && !head_r.act))
    else $error("full store did not drop the element");

  // A stored element can never end a longer run than the sequence best.
  a_len_le_best : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r <= out_best_r))
    else $error("ending length exceeds best length");

endmodule

>>> bench/longest_increasing_subsequence_unit_tb.sv
// Testbench for the streaming longest-increasing-subsequence unit.
`timescale 1ns / 1ps
module longest_increasing_subsequence_unit_tb;
  import lis_pkg::*;

  localparam int SINK_HOLD_CYCLES = 1500;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ELEMENTS = 1100;
  localparam int IDX_W = $clog2(MAX_ITEMS);

  typedef struct packed {
    logic [LEN_W-1:0] ending_length;
    logic [LEN_W-1:0] best_length;
    logic             overflow;
  } lis_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [VAL_W-1:0]       in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Predicted state of the store, kept alongside the block.
  logic signed [VAL_W-1:0] lis_value_store [MAX_ITEMS];
  logic [LEN_W-1:0]        lis_length_store [MAX_ITEMS];
  int unsigned             lis_count;
  logic [LEN_W-1:0]        lis_best;

  lis_result_t lis_expected_q[$];
  int          fail_count;
  int          elements_sent;
  int          burst_left;
  bit          sink_hold_req;

  longest_increasing_subsequence_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic lis_result_t predict_lis_step(input bit start_new,
                                                   input logic signed [VAL_W-1:0] value);
    lis_result_t     res;
    logic [LEN_W:0]  cand;
    logic [LEN_W-1:0] len;
    if (start_new) begin
      lis_count = 0;
      lis_best = '0;
    end
    if (lis_count >= MAX_ITEMS) begin
      res.ending_length = '0;
      res.best_length = lis_best;
      res.overflow = 1'b1;
      return res;
    end
    len = LEN_W'(1);
    for (int j = 0; j < lis_count; j++) begin
      // Equal values do not extend a strictly increasing run.
      if (lis_value_store[IDX_W'(j)] < value) begin
        cand = {1'b0, lis_length_store[IDX_W'(j)]} + 1'b1;
        if (cand > {1'b0, LEN_SAT}) cand = {1'b0, LEN_SAT};
        if (cand[LEN_W-1:0] > len) len = cand[LEN_W-1:0];
      end
    end
    lis_value_store[IDX_W'(lis_count)] = value;
    lis_length_store[IDX_W'(lis_count)] = len;
    lis_count++;
    if (len > lis_best) lis_best = len;
    res.ending_length = len;
    res.best_length = lis_best;
    res.overflow = 1'b0;
    return res;
  endfunction

  // Offers one word, waits for the handshake, then applies the burst pacing.
  task automatic send_element(input bit start_new, input logic signed [VAL_W-1:0] value);
    int gap;
    in_tvalid = 1'b1;
    in_tuser = start_new;
    in_tdata = value;
    do @(posedge clk); while (!in_tready);
    lis_expected_q.insert(lis_expected_q.size(), predict_lis_step(start_new, value));
    elements_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(input int mode,
                                                         input logic signed [VAL_W-1:0] prev);
    logic signed [VAL_W-1:0] v;
    case (mode)
      0: v = $urandom;
      1: v = int'($urandom_range(0, 16)) - 8;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = prev + int'($urandom_range(0, 3)) - 1;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    send_element(1'b0, 0);
    send_element(1'b1, 32'sh8000_0000);
    send_element(1'b0, 32'sh7FFF_FFFF);
    send_element(1'b0, 32'sh7FFF_FFFF);
    send_element(1'b0, -1);
    send_element(1'b0, 0);
    send_element(1'b0, 1);
    send_element(1'b0, 1);
    send_element(1'b0, 32'sh8000_0000);
    send_element(1'b0, 32'sh5555_5555);
    send_element(1'b0, 32'shAAAA_AAAA);
    send_element(1'b1, 32'sh7FFF_FFFF);
    send_element(1'b0, 32'sh8000_0000);
    send_element(1'b1, 10);
    send_element(1'b0, 9);
    send_element(1'b0, 8);
    send_element(1'b0, 8);
    send_element(1'b1, 5);
    send_element(1'b1, 4);
    send_element(1'b0, 6);
    send_element(1'b0, 7);
  endtask

  // A strictly rising run fills the store and reaches the longest length,
  // after which further elements are dropped until a new sequence starts.
  task automatic test_store_full();
    logic [VAL_W-1:0] v;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      v = 32'h8000_0000 + (i << 24);
      send_element(i == 0, v);
    end
    send_element(1'b0, 32'sh7FFF_FFFF);
    send_element(1'b0, $urandom);
    send_element(1'b0, 32'sh8000_0000);
    send_element(1'b1, 5);
    send_element(1'b0, 6);
  endtask

  task automatic test_random();
    int target;
    int seq_len;
    int mode;
    logic signed [VAL_W-1:0] v;
    target = elements_sent + RANDOM_ELEMENTS;
    v = 0;
    while (elements_sent < target) begin
      seq_len = ($urandom_range(0, 15) == 0) ? $urandom_range(MAX_ITEMS, MAX_ITEMS + 40)
                                             : $urandom_range(1, 48);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < seq_len; i++) begin
        v = pick_value(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : mode, v);
        send_element(i == 0 || $urandom_range(0, 49) == 0, v);
      end
    end
  endtask

  // The sink holds off for a long stretch while words keep being offered.
  task automatic test_long_hold();
    logic signed [VAL_W-1:0] v;
    v = 0;
    sink_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      v = pick_value(3, v);
      send_element(i == 0, v);
    end
  endtask

  initial begin : result_sink
    int seg_left;
    int seg_mode;
    int hold_left;
    seg_left = 0;
    seg_mode = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 200);
        end
        seg_left--;
        case (seg_mode)
          0: out_tready = 1'b1;
          1: out_tready = $urandom_range(0, 1);
          2: out_tready = (seg_left % 4 == 0);
          default: out_tready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    lis_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (lis_expected_q.size() == 0) begin
        $error("result word arrived with no expectation pending");
        fail_count++;
      end else begin
        want = lis_expected_q.pop_front();
        if (out_tdata[LEN_W-1:0] !== want.ending_length) begin
          $error("ending_length: expected %0d, actual %0d",
                 want.ending_length, out_tdata[LEN_W-1:0]);
          fail_count++;
        end
        if (out_tdata[2*LEN_W-1:LEN_W] !== want.best_length) begin
          $error("best_length: expected %0d, actual %0d",
                 want.best_length, out_tdata[2*LEN_W-1:LEN_W]);
          fail_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:2*LEN_W] !== '0) begin
          $error("tdata padding: expected 0, actual %0h",
                 out_tdata[OUT_TDATA_W-1:2*LEN_W]);
          fail_count++;
        end
        if (out_tuser !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[longest_increasing_subsequence_unit] ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    lis_count = 0;
    lis_best = '0;
    fail_count = 0;
    elements_sent = 0;
    burst_left = 0;
    sink_hold_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_store_full();
    test_random();
    test_long_hold();
    in_tvalid = 1'b0;
    while (lis_expected_q.size() != 0) @(posedge clk);
    repeat (MAX_ITEMS + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("[longest_increasing_subsequence_unit] OK");
    end else begin
      $display("[longest_increasing_subsequence_unit] ERROR");
    end
    $finish;
  end

endmodule
